// ===== rtl/sxp_pkg.sv =====
// Shared types and constants of the SysEx response parser.
package sxp_pkg;

  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] PREFIX_MARK   = 8'h00;
  localparam logic [7:0] CAT_ACK_NACK  = 8'h7E;
  localparam logic [7:0] CMD_ACK       = 8'h01;
  localparam logic [7:0] CMD_NACK      = 8'h00;
  localparam logic [7:0] REQ_CAT_ALIAS = 8'h02;
  localparam logic [7:0] RSP_CAT_ALIAS = 8'h01;

  localparam logic [23:0] MANUFACTURER_RESET = 24'd8517;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MANUFACTURER = 2'd0;
  localparam logic [1:0] REG_REQ_CATEGORY = 2'd1;
  localparam logic [1:0] REG_REQ_COMMAND  = 2'd2;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  typedef struct packed {
    logic [23:0] manufacturer_id;
    logic [7:0]  request_category;
    logic [7:0]  request_command;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_value;
    logic        message_valid;
    logic [7:0]  category_byte;
    logic [7:0]  command_byte;
    logic        has_transaction;
    logic [13:0] transaction_id;
    logic        ack_flag;
    logic        nack_flag;
    logic        reply_match;
    logic        run_end;
  } result_t;

endpackage

// ===== rtl/sxp_if.sv =====
// Handshake channels for raw message bytes and parser results.
interface sxp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sxp_result_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_value;
  logic        message_valid;
  logic [7:0]  category_byte;
  logic [7:0]  command_byte;
  logic        has_transaction;
  logic [13:0] transaction_id;
  logic        ack_flag;
  logic        nack_flag;
  logic        reply_match;
  logic        run_end;

  modport source (
    output valid, output item_kind, output payload_value, output message_valid,
    output category_byte, output command_byte, output has_transaction,
    output transaction_id, output ack_flag, output nack_flag, output reply_match,
    output run_end, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_value, input message_valid,
    input category_byte, input command_byte, input has_transaction,
    input transaction_id, input ack_flag, input nack_flag, input reply_match,
    input run_end, output ready
  );
endinterface

// ===== rtl/sysex_response_parser.sv =====
// Top level: streaming SysEx response parser with configuration registers.
// Latency: a result joins the four-entry queue the cycle after its byte is accepted.
// Throughput: one byte per cycle while the queue has room; a final byte that releases
//   a held ACK/NACK byte yields two results, taken one per cycle while result_ch is ready.
// Reset (rst, synchronous): parse state cleared, queue emptied, registers
//   back to manufacturer 8517 and request category/command 0.
module sysex_response_parser (
  input  logic        clk,
  input  logic        rst,
  sxp_byte_if.sink    byte_ch,
  sxp_result_if.source result_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import sxp_pkg::*;

  cfg_t       cfg;
  result_t    res0;
  result_t    res1;
  result_t    head;
  logic [1:0] res_count;
  logic       room;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.manufacturer_id  <= MANUFACTURER_RESET;
      cfg.request_category <= 8'd0;
      cfg.request_command  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MANUFACTURER: cfg.manufacturer_id  <= cfg_data;
        REG_REQ_CATEGORY: cfg.request_category <= cfg_data[7:0];
        REG_REQ_COMMAND:  cfg.request_command  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign byte_ch.ready = room;
  assign accept = byte_ch.valid && room;

  sxp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (byte_ch.data_byte),
    .final_byte (byte_ch.final_byte),
    .cfg        (cfg),
    .res0       (res0),
    .res1       (res1),
    .res_count  (res_count)
  );

  sxp_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (res_count),
    .room       (room),
    .head       (head),
    .head_valid (result_ch.valid),
    .head_ready (result_ch.ready)
  );

  assign result_ch.item_kind       = head.item_kind;
  assign result_ch.payload_value   = head.payload_value;
  assign result_ch.message_valid   = head.message_valid;
  assign result_ch.category_byte   = head.category_byte;
  assign result_ch.command_byte    = head.command_byte;
  assign result_ch.has_transaction = head.has_transaction;
  assign result_ch.transaction_id  = head.transaction_id;
  assign result_ch.ack_flag        = head.ack_flag;
  assign result_ch.nack_flag       = head.nack_flag;
  assign result_ch.reply_match     = head.reply_match;
  assign result_ch.run_end         = head.run_end;

  // a closing byte always leaves at least its summary queued
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && byte_ch.final_byte |=> result_ch.valid)
    else $error("no result after final byte");

  a_invalid_summary_clear: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.item_kind == ITEM_SUMMARY && !result_ch.message_valid
    |-> result_ch.category_byte == 8'd0 && result_ch.command_byte == 8'd0
        && !result_ch.has_transaction && !result_ch.reply_match)
    else $error("invalid summary carries fields");

  a_payload_no_summary: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.item_kind == ITEM_PAYLOAD
    |-> !result_ch.message_valid && !result_ch.ack_flag && !result_ch.nack_flag)
    else $error("payload transaction carries summary flags");

  a_ack_nack_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> !(result_ch.ack_flag && result_ch.nack_flag))
    else $error("ack and nack both set");

endmodule

// ===== rtl/sxp_parser.sv =====
// Per-message parse state and result generation for one accepted byte.
module sxp_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  input  sxp_pkg::cfg_t   cfg,
  output sxp_pkg::result_t res0,
  output sxp_pkg::result_t res1,
  output logic [1:0]      res_count
);
  import sxp_pkg::*;

  logic [3:0]  byte_position, byte_position_next;
  logic        frame_error, frame_error_next;
  logic        prefix_seen, prefix_seen_next;
  logic [13:0] held_transaction, held_transaction_next;
  logic [7:0]  held_category, held_category_next;
  logic [7:0]  held_command, held_command_next;
  logic [1:0]  payload_count, payload_count_next;
  logic [7:0]  ack_payload_bytes [2];

  logic        ackn;
  logic        is_payload;
  logic        hold_write;
  logic        past_cmd;
  logic        msg_ok;
  logic        is_ack;
  logic        is_nack;
  logic        match;
  logic [7:0]  want;
  result_t     summary;

  assign is_ack  = (held_category == CAT_ACK_NACK) && (held_command == CMD_ACK);
  assign is_nack = (held_category == CAT_ACK_NACK) && (held_command == CMD_NACK);
  assign ackn    = is_ack || is_nack;
  assign past_cmd = prefix_seen ? (byte_position >= 4'd9) : (byte_position >= 4'd6);
  assign msg_ok  = !frame_error && (data_byte == SYSEX_END) && past_cmd;
  assign match   = ackn
                || ((cfg.request_category == REQ_CAT_ALIAS) && (held_category == RSP_CAT_ALIAS)
                    && (held_command == cfg.request_command))
                || ((held_category == cfg.request_category)
                    && (held_command == cfg.request_command));

  always_comb begin
    case (byte_position[1:0])
      2'd1:    want = cfg.manufacturer_id[23:16];
      2'd2:    want = cfg.manufacturer_id[15:8];
      2'd3:    want = cfg.manufacturer_id[7:0];
      default: want = 8'h00;
    endcase
  end

  // Header decode and payload flagging for a byte that is not the last of the message.
  always_comb begin
    frame_error_next      = frame_error;
    prefix_seen_next      = prefix_seen;
    held_transaction_next = held_transaction;
    held_category_next    = held_category;
    held_command_next     = held_command;
    is_payload            = 1'b0;
    if (byte_position == 4'd0) begin
      if (data_byte != SYSEX_START) frame_error_next = 1'b1;
    end else if (byte_position <= 4'd3) begin
      if (data_byte != want) frame_error_next = 1'b1;
    end else if (byte_position == 4'd4) begin
      if (data_byte == PREFIX_MARK) prefix_seen_next = 1'b1;
      else held_category_next = data_byte;
    end else if (prefix_seen) begin
      case (byte_position)
        4'd5:    held_transaction_next = {held_transaction[13:7], data_byte[6:0]};
        4'd6:    held_transaction_next = {data_byte[6:0], held_transaction[6:0]};
        4'd7:    held_category_next = data_byte;
        4'd8:    held_command_next = data_byte;
        default: is_payload = 1'b1;
      endcase
    end else begin
      if (byte_position == 4'd5) held_command_next = data_byte;
      else is_payload = 1'b1;
    end
  end

  assign hold_write = accept && !final_byte && is_payload && ackn && (payload_count < 2'd2);

  always_comb begin
    summary = '0;
    summary.item_kind = ITEM_SUMMARY;
    summary.run_end   = 1'b1;
    if (msg_ok) begin
      summary.message_valid = 1'b1;
      summary.category_byte = held_category;
      summary.command_byte  = held_command;
      summary.ack_flag      = is_ack;
      summary.nack_flag     = is_nack;
      summary.reply_match   = match;
      // trailing id of an ACK/NACK wins over the prefix id
      if (ackn && payload_count >= 2'd2) begin
        summary.has_transaction = 1'b1;
        summary.transaction_id  = {ack_payload_bytes[1][6:0], ack_payload_bytes[0][6:0]};
      end else if (prefix_seen) begin
        summary.has_transaction = 1'b1;
        summary.transaction_id  = held_transaction;
      end
    end
  end

  always_comb begin
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;
    if (accept) begin
      if (final_byte) begin
        if (ackn && past_cmd && payload_count == 2'd1) begin
          res0.item_kind     = ITEM_PAYLOAD;
          res0.payload_value = ack_payload_bytes[0];
          res1      = summary;
          res_count = 2'd2;
        end else begin
          res0      = summary;
          res_count = 2'd1;
        end
      end else if (is_payload && !ackn) begin
        res0.item_kind     = ITEM_PAYLOAD;
        res0.payload_value = data_byte;
        res0.run_end       = 1'b1;
        res_count = 2'd1;
      end
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    payload_count_next = payload_count;
    if (accept) begin
      if (final_byte) begin
        byte_position_next = 4'd0;
        payload_count_next = 2'd0;
      end else begin
        if (byte_position != 4'hF) byte_position_next = byte_position + 4'd1;
        if (hold_write) payload_count_next = payload_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 4'd0;
      frame_error      <= 1'b0;
      prefix_seen      <= 1'b0;
      held_transaction <= 14'd0;
      held_category    <= 8'd0;
      held_command     <= 8'd0;
      payload_count    <= 2'd0;
    end else begin
      byte_position <= byte_position_next;
      payload_count <= payload_count_next;
      if (accept) begin
        if (final_byte) begin
          frame_error      <= 1'b0;
          prefix_seen      <= 1'b0;
          held_transaction <= 14'd0;
          held_category    <= 8'd0;
          held_command     <= 8'd0;
        end else begin
          frame_error      <= frame_error_next;
          prefix_seen      <= prefix_seen_next;
          held_transaction <= held_transaction_next;
          held_category    <= held_category_next;
          held_command     <= held_command_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_write) ack_payload_bytes[payload_count[0]] <= data_byte;
  end

endmodule

// ===== rtl/sxp_result_queue.sv =====
// Four-entry result queue: takes up to two results a cycle while room is high, gives one when head_ready.
module sxp_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  sxp_pkg::result_t push0,
  input  sxp_pkg::result_t push1,
  input  logic [1:0]       push_count,
  output logic             room,
  output sxp_pkg::result_t head,
  output logic             head_valid,
  input  logic             head_ready
);
  import sxp_pkg::*;

  localparam logic [2:0] ROOM_LIMIT = 3'd2;

  result_t    entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       pop;

  assign head_valid = (fill != 3'd0);
  assign head       = entries[rd_ptr];
  assign pop        = head_valid && head_ready;
  assign room       = (fill <= ROOM_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill + {1'b0, push_count} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr + 2'd1] <= push1;
  end

endmodule
